### sv/ffp_pkg.sv
// Package of shared types and constants for the frame fragment packetizer.
package ffp_pkg;

   localparam int BUFFER_BYTES     = 65536;
   localparam int PKT_BYTES        = 256;
   localparam int DESCRIPTOR_DEPTH = 64;
   localparam int PAYLOAD_WORDS    = (PKT_BYTES + 7) / 8;
   localparam int BUF_AW  = $clog2(BUFFER_BYTES);
   localparam int DESC_AW = $clog2(DESCRIPTOR_DEPTH);
   localparam int WORD_W  = $clog2(PAYLOAD_WORDS + 1);
   localparam int DESC_W  = 34;

   typedef enum logic [1:0] {
      FUNC_DESC  = 2'd0,
      FUNC_BYTE  = 2'd1,
      FUNC_PKT   = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] frame_number;
      logic [16:0] frame_bytes;
      logic        key_frame;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] seq_number;
      logic [15:0] frame_id_out;
      logic [15:0] fragment_index;
      logic        keyframe_flag;
      logic        start_flag;
      logic        end_flag;
      logic        padding_flag;
      logic [8:0]  payload_length;
      logic [16:0] buffered_count;
      logic [63:0] payload_word;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_HEAD,
      ST_FETCH,
      ST_WORD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // act on a descriptor, byte or clear request
      logic load;     // pop a descriptor if the current frame is finished and one is queued
      logic head;     // compute packet length and emit the header
      logic fetch;    // read one payload byte while any remain
      logic word;     // emit the assembled payload word
   } cmd_type;

   typedef struct packed {
      logic byte_due;   // more payload bytes to fetch for this word
      logic last_word;  // the word about to be sent is the final one
   } status_type;

endpackage

### sv/ffp_ram.sv
// Generic single-port write, registered-read RAM.
module ffp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### sv/ffp_ctrl.sv
// Controller state machine sequencing requests and packet emission.
module ffp_ctrl
   import ffp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] func,
   input  status_type status,
   output logic       busy,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept = 1'b1;
               if (func == FUNC_PKT) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            cmd.head = 1'b1;
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            // One byte per cycle; the RAM read is registered.
            if (status.byte_due) begin
               cmd.fetch = 1'b1;
            end else begin
               state_in = ST_WORD;
            end
         end
         ST_WORD: begin
            cmd.word = 1'b1;
            state_in = status.last_word ? ST_IDLE : ST_FETCH;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

### sv/ffp_dp.sv
// Datapath: byte and descriptor FIFOs, counters and result assembly.
module ffp_dp
   import ffp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp
);
   logic [BUF_AW-1:0]  wptr_ff, rptr_ff;
   logic [16:0]        stored_ff, reserved_ff;
   logic [DESC_AW-1:0] dwr_ff, drd_ff;
   logic [DESC_AW:0]   dcount_ff;
   logic [15:0]        cur_frame_ff, frag_ff, seq_ff;
   logic               cur_key_ff, keep_ff;
   logic [16:0]        cur_rem_ff, in_left_ff;
   logic [8:0]         len_ff, taken_ff;
   logic [3:0]         bidx_ff;
   logic [WORD_W-1:0]  widx_ff;
   logic [63:0]        word_ff, word_in;
   logic               pend_ff;
   logic [2:0]         pend_pos_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic [7:0]         byte_rd;
   logic [DESC_W-1:0]  desc_rd;
   logic               byte_we, desc_we;
   logic [DESC_W-1:0]  desc_wd;
   logic [DESC_AW-1:0] desc_wa;

   ffp_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_bytes (
      .clock(clock), .wr_en(byte_we), .wr_addr(wptr_ff), .wr_data(req.data_byte),
      .rd_addr(rptr_ff), .rd_data(byte_rd));

   ffp_ram #(.WIDTH(DESC_W), .DEPTH(DESCRIPTOR_DEPTH)) u_desc (
      .clock(clock), .wr_en(desc_we), .wr_addr(desc_wa), .wr_data(desc_wd),
      .rd_addr(drd_ff), .rd_data(desc_rd));

   logic        is_desc, is_byte, is_clear, overflow, too_big, take_desc;
   logic [17:0] total;
   logic [16:0] len_calc;

   assign is_desc  = cmd.accept && req.func == FUNC_DESC && req.frame_bytes != '0
                     && in_left_ff == '0;
   assign is_byte  = cmd.accept && req.func == FUNC_BYTE && in_left_ff != '0;
   assign is_clear = cmd.accept && req.func == FUNC_CLEAR;
   assign total    = 18'(stored_ff) + 18'(reserved_ff) + 18'(req.frame_bytes);
   assign overflow = total > 18'(BUFFER_BYTES) || dcount_ff >= (DESC_AW+1)'(DESCRIPTOR_DEPTH);
   assign too_big  = 18'(req.frame_bytes) > 18'(BUFFER_BYTES);
   assign take_desc = is_desc && !too_big && (!overflow || req.key_frame);
   assign desc_we  = take_desc;
   // After a flush the key frame becomes the first entry of the emptied FIFO.
   assign desc_wa  = overflow ? '0 : dwr_ff;
   assign desc_wd  = {req.key_frame, req.frame_bytes, req.frame_number};
   assign byte_we  = is_byte && keep_ff;

   always_comb begin
      len_calc = 17'(PKT_BYTES);
      if (cur_rem_ff < len_calc) len_calc = cur_rem_ff;
      if (stored_ff < len_calc) len_calc = stored_ff;
      if (stored_ff == '0 || cur_rem_ff == '0) len_calc = '0;
   end

   assign status.byte_due  = bidx_ff != 4'd8;
   assign status.last_word = widx_ff == WORD_W'(PAYLOAD_WORDS - 1);

   logic fetch_now;
   assign fetch_now = cmd.fetch && taken_ff < len_ff;

   always_comb begin
      word_in = word_ff;
      if (cmd.head || cmd.word) begin
         word_in = '0;
      end else if (pend_ff) begin
         word_in[pend_pos_ff*8 +: 8] = byte_rd;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (cmd.word) begin
         rsp_in.kind         = 1'b1;
         rsp_in.payload_word = word_ff;
         rsp_in.last         = status.last_word;
      end else begin
         rsp_in.seq_number     = seq_ff;
         rsp_in.frame_id_out   = cur_frame_ff;
         rsp_in.padding_flag   = len_calc == '0;
         rsp_in.payload_length = len_calc[8:0];
         rsp_in.buffered_count = stored_ff - len_calc;
         if (len_calc != '0) begin
            rsp_in.fragment_index = frag_ff;
            rsp_in.keyframe_flag  = cur_key_ff;
            rsp_in.start_flag     = frag_ff == '0;
            rsp_in.end_flag       = len_calc >= cur_rem_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= !reset && (cmd.head || cmd.word);
      pend_ff      <= !reset && fetch_now;
      pend_pos_ff  <= bidx_ff[2:0];
      word_ff      <= word_in;
      if (cmd.head || cmd.word) begin
         rsp_ff <= rsp_in;
      end
      if (reset || is_clear) begin
         wptr_ff <= '0; rptr_ff <= '0; stored_ff <= '0; reserved_ff <= '0;
         dwr_ff <= '0; drd_ff <= '0; dcount_ff <= '0; cur_rem_ff <= '0;
         frag_ff <= '0; cur_frame_ff <= '0; cur_key_ff <= 1'b0; seq_ff <= '0;
         in_left_ff <= '0; keep_ff <= 1'b0;
         len_ff <= '0; taken_ff <= '0; bidx_ff <= '0; widx_ff <= '0;
      end else begin
         if (is_desc) begin
            in_left_ff <= req.frame_bytes;
            keep_ff    <= take_desc;
            if (take_desc) begin
               if (overflow) begin
                  // Key frame flushes everything held so far.
                  wptr_ff <= '0; rptr_ff <= '0; stored_ff <= '0;
                  reserved_ff <= req.frame_bytes;
                  dwr_ff <= DESC_AW'(1); drd_ff <= '0; dcount_ff <= (DESC_AW+1)'(1);
                  cur_rem_ff <= '0; frag_ff <= '0;
               end else begin
                  dwr_ff      <= dwr_ff + DESC_AW'(1);
                  dcount_ff   <= dcount_ff + (DESC_AW+1)'(1);
                  reserved_ff <= reserved_ff + req.frame_bytes;
               end
            end
         end
         if (is_byte) begin
            in_left_ff <= in_left_ff - 17'd1;
            if (keep_ff) begin
               wptr_ff   <= wptr_ff + BUF_AW'(1);
               stored_ff <= stored_ff + 17'd1;
               if (reserved_ff != '0) reserved_ff <= reserved_ff - 17'd1;
            end
         end
         if (cmd.load && cur_rem_ff == '0 && dcount_ff != '0) begin
            cur_frame_ff <= desc_rd[15:0];
            cur_rem_ff   <= desc_rd[32:16];
            cur_key_ff   <= desc_rd[33];
            frag_ff      <= '0;
            drd_ff       <= drd_ff + DESC_AW'(1);
            dcount_ff    <= dcount_ff - (DESC_AW+1)'(1);
         end
         if (cmd.head) begin
            if (len_calc != '0) begin
               cur_rem_ff <= cur_rem_ff - len_calc;
               frag_ff    <= frag_ff + 16'd1;
            end
            seq_ff   <= seq_ff + 16'd1;
            len_ff   <= len_calc[8:0];
            taken_ff <= '0;
            bidx_ff  <= '0;
            widx_ff  <= '0;
         end
         if (cmd.fetch) begin
            bidx_ff <= bidx_ff + 4'd1;
            if (fetch_now) begin
               rptr_ff   <= rptr_ff + BUF_AW'(1);
               stored_ff <= stored_ff - 17'd1;
               taken_ff  <= taken_ff + 9'd1;
            end
         end
         if (cmd.word) begin
            bidx_ff <= '0;
            widx_ff <= widx_ff + WORD_W'(1);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
endmodule

### sv/frame_fragment_packetizer_top.sv
// Top level of the frame fragment packetizer.
// Channel   | Direction | Handshake            | Payload
// request   | in        | start, busy          | req_data (req_type)
// result    | out       | rsp_valid strobe     | rsp_data (rsp_type)
// Descriptor, byte and clear requests leave the controller idle; busy stays low.
// A packet request passes through the load and header states; then for each payload word
// one byte per cycle is read from the byte RAM's single read port, eight reads per word,
// followed by a wait for the last read to land and one emit state.
// Reset is synchronous and clears all counters; the RAM contents are not cleared.
// Results cannot be stalled: each is presented for one cycle on rsp_valid.
module frame_fragment_packetizer_top
   import ffp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   cmd_type    cmd;
   status_type status;

   ffp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .func(req_data.func),
      .status(status), .busy(busy), .cmd(cmd));

   ffp_dp u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .status(status),
      .rsp_valid(rsp_valid), .rsp(rsp_data));

   a_no_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy)) |-> !rsp_valid)
      else $error("result strobed while idle");
   a_word_zero_hdr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind) |->
         (rsp_data.seq_number == '0 && rsp_data.payload_length == '0))
      else $error("payload word carries header fields");
   a_pad_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.kind && rsp_data.padding_flag) |->
         rsp_data.payload_length == '0)
      else $error("padding packet with payload");
endmodule

### verif/tb.sv
// Testbench for the frame fragment packetizer: requests checked against a predictor.
module tb
   import ffp_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;

   frame_fragment_packetizer_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req), .rsp_valid(rsp_valid), .rsp_data(rsp)
   );

   // Predictor state
   logic [7:0]  pk_bytes [BUFFER_BYTES];
   logic [15:0] pk_desc_id [DESCRIPTOR_DEPTH];
   logic [16:0] pk_desc_size [DESCRIPTOR_DEPTH];
   logic        pk_desc_key [DESCRIPTOR_DEPTH];
   int unsigned pk_wr, pk_rd, pk_stored, pk_reserved;
   int unsigned pk_dwr, pk_drd, pk_dcount;
   int unsigned pk_frame, pk_key, pk_remaining, pk_frag, pk_seq;
   int unsigned pk_in_left, pk_in_keep;

   rsp_type     expected_items [$];
   req_type     pending_requests [$];
   int          errors = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 31;
   bit          stim_done = 0;

   localparam int CYCLE_LIMIT = 2000000;

   task automatic enqueue(input req_type r);
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic expect_item(input rsp_type x);
      expected_items.insert(expected_items.size(), x);
   endtask

   task automatic clear_fifos();
      pk_wr = 0; pk_rd = 0; pk_stored = 0; pk_reserved = 0;
      pk_dwr = 0; pk_drd = 0; pk_dcount = 0; pk_remaining = 0; pk_frag = 0;
   endtask

   task automatic clear_all();
      clear_fifos();
      pk_frame = 0; pk_key = 0; pk_seq = 0; pk_in_left = 0; pk_in_keep = 0;
   endtask

   task automatic predict_packet();
      rsp_type h;
      rsp_type p;
      int unsigned len;
      int unsigned taken;
      logic [63:0] w;
      len = 0;
      taken = 0;
      h = '0;
      if (pk_remaining == 0 && pk_dcount > 0) begin
         pk_frame = pk_desc_id[pk_drd];
         pk_remaining = pk_desc_size[pk_drd];
         pk_key = pk_desc_key[pk_drd];
         pk_frag = 0;
         pk_drd = (pk_drd + 1) % DESCRIPTOR_DEPTH;
         pk_dcount--;
      end
      if (pk_stored == 0 || pk_remaining == 0) begin
         h.padding_flag = 1'b1;
      end else begin
         len = PKT_BYTES;
         if (pk_remaining < len) len = pk_remaining;
         if (pk_stored < len) len = pk_stored;
         h.start_flag = (pk_frag == 0);
         h.end_flag = (len >= pk_remaining);
         h.keyframe_flag = pk_key[0];
         h.fragment_index = pk_frag[15:0];
         pk_remaining -= len;
         pk_frag = (pk_frag + 1) & 16'hFFFF;
      end
      h.seq_number = pk_seq[15:0];
      h.frame_id_out = pk_frame[15:0];
      h.payload_length = len[8:0];
      h.buffered_count = 17'(pk_stored - len);
      pk_seq = (pk_seq + 1) & 16'hFFFF;
      expect_item(h);
      for (int i = 0; i < PAYLOAD_WORDS; i++) begin
         w = '0;
         for (int b = 0; b < 8; b++) begin
            if (taken < len) begin
               w[8*b +: 8] = pk_bytes[pk_rd];
               pk_rd = (pk_rd + 1) % BUFFER_BYTES;
               pk_stored--;
               taken++;
            end
         end
         p = '0;
         p.kind = 1'b1;
         p.payload_word = w;
         p.last = (i == PAYLOAD_WORDS - 1);
         expect_item(p);
      end
   endtask

   task automatic predict_request(input req_type r);
      int unsigned sz;
      bit          ovf;
      sz = r.frame_bytes;
      case (func_type'(r.func))
         FUNC_DESC: begin
            if (sz != 0 && pk_in_left == 0) begin
               ovf = (pk_stored + pk_reserved + sz > BUFFER_BYTES) ||
                     (pk_dcount >= DESCRIPTOR_DEPTH);
               pk_in_left = sz;
               if (sz > BUFFER_BYTES || (ovf && !r.key_frame)) begin
                  pk_in_keep = 0;
               end else begin
                  if (ovf) clear_fifos();
                  pk_desc_id[pk_dwr] = r.frame_number;
                  pk_desc_size[pk_dwr] = r.frame_bytes;
                  pk_desc_key[pk_dwr] = r.key_frame;
                  pk_dwr = (pk_dwr + 1) % DESCRIPTOR_DEPTH;
                  pk_dcount++;
                  pk_reserved += sz;
                  pk_in_keep = 1;
               end
            end
         end
         FUNC_BYTE: begin
            if (pk_in_left != 0) begin
               pk_in_left--;
               if (pk_in_keep) begin
                  pk_bytes[pk_wr] = r.data_byte;
                  pk_wr = (pk_wr + 1) % BUFFER_BYTES;
                  pk_stored++;
                  if (pk_reserved > 0) pk_reserved--;
               end
            end
         end
         FUNC_PKT: predict_packet();
         default: clear_all();
      endcase
   endtask

   // Request builders
   function automatic req_type make_req(input func_type f, input logic [15:0] id,
                                        input logic [16:0] sz, input logic k,
                                        input logic [7:0] d);
      req_type r;
      r.func = f;
      r.frame_number = id;
      r.frame_bytes = sz;
      r.key_frame = k;
      r.data_byte = d;
      return r;
   endfunction

   function automatic req_type noise_req(input func_type f);
      return make_req(f, 16'($urandom), 17'($urandom), 1'($urandom), 8'($urandom));
   endfunction

   task automatic queue_frame(input int unsigned sz, input int unsigned pushed,
                              input logic k);
      enqueue(make_req(FUNC_DESC, 16'($urandom), 17'(sz), k, 8'($urandom)));
      for (int i = 0; i < pushed; i++)
         enqueue(noise_req(FUNC_BYTE));
   endtask

   // Clock and reset
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;
   end

   // Driver: one request per accepted handshake, random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         req <= '0;
      end else begin
         if (start && !busy) pending_requests.delete(0);
         if ((!start || !busy) || !start) begin
            if (pending_requests.size() > (start && !busy ? 0 : 0) &&
                $urandom_range(99) >= send_idle_pct) begin
               start <= 1;
               req <= pending_requests[0];
            end else begin
               start <= 0;
            end
         end
      end
   end

   // Prediction is taken at acceptance; the accepted request is still on req
   always @(posedge clock) begin
      if (!reset && start && !busy) predict_request(req);
   end

   // Monitor
   always @(posedge clock) begin
      rsp_type e;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         if (expected_items.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, rsp);
            errors++;
         end else begin
            e = expected_items[0];
            expected_items.delete(0);
            if (rsp !== e) begin
               $display("%0t: mismatch expected %h actual %h", $time, e, rsp);
               errors++;
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_requests.size() > 0 || start || expected_items.size() > 0)
         @(posedge clock);
   endtask

   int unsigned rsz;
   int unsigned rsel;

   initial begin
      @(negedge reset);
      @(posedge clock);
      // Directed: padding, ignored requests, one-byte frame, partly arrived frame
      enqueue(noise_req(FUNC_PKT));
      enqueue(make_req(FUNC_BYTE, 16'hFFFF, 17'd0, 1'b1, 8'hFF));
      enqueue(make_req(FUNC_DESC, 16'h1234, 17'd0, 1'b1, 8'h00));
      queue_frame(1, 1, 1'b1);
      enqueue(make_req(FUNC_PKT, 16'h0000, 17'd0, 1'b0, 8'h00));
      queue_frame(12, 6, 1'b0);
      enqueue(make_req(FUNC_DESC, 16'hFFFF, 17'h1FFFF, 1'b1, 8'h00));
      enqueue(make_req(FUNC_PKT, 16'h0000, 17'd0, 1'b0, 8'h00));
      for (int i = 0; i < 6; i++) enqueue(noise_req(FUNC_BYTE));
      enqueue(make_req(FUNC_PKT, 16'h0000, 17'd0, 1'b0, 8'h00));
      enqueue(make_req(FUNC_PKT, 16'h0000, 17'd0, 1'b0, 8'h00));
      // Oversized key frame is dropped; its bytes are counted off
      queue_frame(65537, 3, 1'b1);
      enqueue(make_req(FUNC_CLEAR, 16'hFFFF, 17'h1FFFF, 1'b1, 8'hFF));
      enqueue(make_req(FUNC_PKT, 16'h0000, 17'd0, 1'b0, 8'h00));
      // Fill the descriptor FIFO with one-byte frames to reach its overflow
      for (int i = 0; i < DESCRIPTOR_DEPTH + 1; i++) queue_frame(1, 1, 1'b0);
      queue_frame(2, 2, 1'b1);
      enqueue(make_req(FUNC_PKT, 16'h0000, 17'd0, 1'b0, 8'h00));
      queue_frame(65536, 0, 1'b0);
      queue_frame(65536, 0, 1'b1);
      enqueue(make_req(FUNC_CLEAR, 16'h0000, 17'd0, 1'b0, 8'h00));
      wait_drained();
      // Random phases: sender idles 31%, then 88%, then never
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 88 : 0;
         for (int n = 0; n < 3; n++) begin
            rsel = $urandom_range(99);
            if (rsel < 50) begin
               rsz = $urandom_range(8, 1);
               queue_frame(rsz, ($urandom_range(3) == 0) ? $urandom_range(rsz) : rsz,
                           1'($urandom));
            end else if (rsel < 85) begin
               enqueue(noise_req(FUNC_PKT));
            end else if (rsel < 95) begin
               enqueue(noise_req(FUNC_DESC));
            end else begin
               enqueue(noise_req(FUNC_CLEAR));
            end
         end
         wait_drained();
      end
      repeat (3 + 10 * PAYLOAD_WORDS + 20) @(posedge clock);
      if (errors == 0 && expected_items.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
